FILE: src/plcmt_pkg.sv
// Shared types and constants for the multimode PLC-style timer.
package plcmt_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned DurW     = 31;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;

  typedef enum logic [ModeW-1:0] {
    MODE_HELD_PULSE = 3'd0,
    MODE_PULSE      = 3'd1,
    MODE_ON_DELAY   = 3'd2,
    MODE_LATCH_ON   = 3'd3,
    MODE_OFF_DELAY  = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE     = 2'd0,
    CFG_DURATION = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic             condition;
    logic             reset_req;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic             timer_out;
    logic [TimeW-1:0] remaining;
  } out_item_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DurW-1:0]  duration;
  } cfg_t;

endpackage

FILE: src/plcmt_in_if.sv
// Input channel of the timer: valid/ready plus one input item.
interface plcmt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         condition;
  logic                         reset_req;
  logic [plcmt_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, condition, reset_req, now_ms, input ready);
  modport sink   (input valid, condition, reset_req, now_ms, output ready);
endinterface

FILE: src/plcmt_out_if.sv
// Output channel of the timer: valid/ready plus one result item.
interface plcmt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         timer_out;
  logic [plcmt_pkg::TimeW-1:0]  remaining;

  modport source (output valid, timer_out, remaining, input ready);
  modport sink   (input valid, timer_out, remaining, output ready);
endinterface

FILE: src/plc_style_multimode_timer_unit.sv
// An accepted beat sits in the input register, then its result in the result register.
// Throughput: one beat per cycle unless the result stalls; the timer state updates in a single pass per beat.
// Input and result registers decouple the two channels, so a stalled result
// still lets one new beat in.
// Reset (rst_ni low, async): config, timer state and valid flags clear to zero.
module plc_style_multimode_timer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [plcmt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [plcmt_pkg::CfgDataW-1:0]   cfg_data_i,
  plcmt_in_if.sink                         in_i,
  plcmt_out_if.source                      out_o
);
  import plcmt_pkg::*;

  cfg_t      cfg_q;
  logic      in_vld_q, out_vld_q, advance;
  in_item_t  in_q;
  out_item_t out_q, res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:     cfg_q.mode     <= cfg_data_i[ModeW-1:0];
        CFG_DURATION: cfg_q.duration <= cfg_data_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready  = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.condition <= in_i.condition;
      in_q.reset_req <= in_i.reset_req;
      in_q.now_ms    <= in_i.now_ms;
    end
  end

  plcmt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.timer_out = out_q.timer_out;
  assign out_o.remaining = out_q.remaining;

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.reset_req |=> !out_o.timer_out)
    else $error("timer_out set after a reset beat");

  a_reset_loads_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.reset_req |=> out_o.remaining == {1'b0, $past(cfg_q.duration)})
    else $error("remaining not preset after a reset beat");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_o.valid)
    else $error("result beat lost");
`endif

endmodule

FILE: src/plcmt_core.sv
// Timer state registers and the per-beat update logic.
module plcmt_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  plcmt_pkg::in_item_t   item_i,
  input  plcmt_pkg::cfg_t       cfg_i,
  output plcmt_pkg::out_item_t  res_o
);
  import plcmt_pkg::*;

  logic             prev_cond_q, prev_cond_d;
  logic             running_q, running_d;
  logic             out_q, out_d;
  logic             prev_out_q, prev_out_d;
  logic [TimeW-1:0] target_q, target_d;
  logic [TimeW-1:0] rem_q, rem_d;

  logic             cond, rst, rise, fall, expired, load, out_fell, out_rose;
  logic [TimeW-1:0] now, dur_ext;

  always_comb begin
    cond    = item_i.condition;
    rst     = item_i.reset_req;
    now     = item_i.now_ms;
    dur_ext = {1'b0, cfg_i.duration};
    rise    = cond & ~prev_cond_q;
    fall    = ~cond & prev_cond_q;

    running_d = running_q;
    out_d     = out_q;
    rem_d     = rem_q;
    out_fell  = 1'b0;
    out_rose  = 1'b0;

    // Edge loads of the target; latching mode only rearms while output is low
    load = ~rst & ((rise & (cfg_i.mode < ModeW'(MODE_LATCH_ON)))
                 | (rise & (cfg_i.mode == MODE_LATCH_ON) & ~out_q)
                 | (fall & (cfg_i.mode == MODE_OFF_DELAY)));
    target_d = load ? now + dur_ext : target_q;
    if (fall && !rst && cfg_i.mode == MODE_OFF_DELAY) begin
      running_d = 1'b1;
    end

    expired = now > target_d;

    if (rst) begin
      out_d     = 1'b0;
      running_d = 1'b0;
      rem_d     = dur_ext;
    end else begin
      unique case (cfg_i.mode)
        MODE_HELD_PULSE: begin
          if (rise) begin out_d = 1'b1; running_d = 1'b1; end
          if (expired || !cond) begin out_d = 1'b0; running_d = 1'b0; end
        end
        MODE_PULSE: begin
          if (rise) begin out_d = 1'b1; running_d = 1'b1; end
          if (expired) begin out_d = 1'b0; running_d = 1'b0; end
        end
        MODE_ON_DELAY: begin
          if (rise) running_d = 1'b1;
          if (cond && expired && running_d && !out_d) begin
            out_d = 1'b1; running_d = 1'b0;
          end
          if (!cond) begin out_d = 1'b0; running_d = 1'b0; end
        end
        MODE_LATCH_ON: begin
          if (rise) running_d = 1'b1;
          if (running_d && expired) begin out_d = 1'b1; running_d = 1'b0; end
        end
        MODE_OFF_DELAY: begin
          if (cond || running_d) out_d = 1'b1;
          if (running_d && expired) begin out_d = 1'b0; running_d = 1'b0; end
        end
        default: ;
      endcase

      out_fell = prev_out_q & ~out_d;
      out_rose = ~prev_out_q & out_d;

      unique case (cfg_i.mode)
        MODE_HELD_PULSE, MODE_PULSE: begin
          if (out_fell) rem_d = '0;
          if (!running_d && !cond) rem_d = dur_ext;
        end
        MODE_ON_DELAY: begin
          if (out_rose) rem_d = '0;
          if (!running_d && !cond) rem_d = dur_ext;
        end
        MODE_LATCH_ON: begin
          if (out_rose) rem_d = '0;
          if (!running_d && !out_d) rem_d = dur_ext;
        end
        MODE_OFF_DELAY: begin
          if (!running_d) rem_d = dur_ext;
        end
        default: ;
      endcase
    end

    if (running_d) rem_d = target_d - now;

    prev_cond_d = cond;
    prev_out_d  = out_d;

    res_o.timer_out = out_d;
    res_o.remaining = rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cond_q <= 1'b0;
      running_q   <= 1'b0;
      out_q       <= 1'b0;
      prev_out_q  <= 1'b0;
      target_q    <= '0;
      rem_q       <= '0;
    end else if (step_i) begin
      prev_cond_q <= prev_cond_d;
      running_q   <= running_d;
      out_q       <= out_d;
      prev_out_q  <= prev_out_d;
      target_q    <= target_d;
      rem_q       <= rem_d;
    end
  end

endmodule
